@@ src/chpe_pkg.sv @@
package chpe_pkg;

    // Fixed-point format and table size
    localparam int MAX_ORDER  = 15;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_CELLS  = MAX_ORDER + 1;
    localparam int CELL_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int ORD_W      = 4;
    localparam int IDX_W      = 4;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    // two shifted products plus a coefficient need two guard bits
    localparam int SUM_W      = PROD_W - FRAC_BITS + 2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SUM_W-1:0]      t_sum;

    // Saturation bounds in the wide sum format
    localparam t_sum SUM_MAX = {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam t_sum SUM_MIN = ~SUM_MAX;

    // Operation codes of the input word
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    // Partial Horner value handed from one cell to the next
    typedef struct packed {
        logic  valid;
        t_data y_re;
        t_data y_im;
        t_data x_re;
        t_data x_im;
        logic  ovf;
    } t_link;

endpackage

@@ src/chpe_if.sv @@
interface chpe_in_if import chpe_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             func;
    logic [IDX_W-1:0] coef_index;
    t_data            coef_re;
    t_data            coef_im;
    t_data            x_re;
    t_data            x_im;

    modport source (output valid, func, coef_index, coef_re, coef_im, x_re, x_im,
                    input ready);
    modport sink   (input valid, func, coef_index, coef_re, coef_im, x_re, x_im,
                    output ready);
endinterface

interface chpe_out_if import chpe_pkg::*; ;
    logic  valid;
    logic  ready;
    t_data y_re;
    t_data y_im;
    logic  overflow;

    modport source (output valid, y_re, y_im, overflow, input ready);
    modport sink   (input valid, y_re, y_im, overflow, output ready);
endinterface

@@ src/chpe_cell.sv @@
module chpe_cell import chpe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_link i_link,
    input  logic  i_wr,
    input  t_data i_wr_re,
    input  t_data i_wr_im,
    output t_link o_link,
    output t_data o_coef_re,
    output t_data o_coef_im
);

    t_data r_coef_re;
    t_data r_coef_im;

    logic  r_v1;
    logic  r_ovf1;
    t_data r_x_re;
    t_data r_x_im;
    t_prod r_p_rr;
    t_prod r_p_ii;
    t_prod r_p_ri;
    t_prod r_p_ir;

    t_link r_link;

    t_sum  w_sum_re;
    t_sum  w_sum_im;
    t_data w_sat_re;
    t_data w_sat_im;
    logic  w_ovf_re;
    logic  w_ovf_im;

    // Clamp a wide sum to the data range
    function automatic t_data sat(input t_sum v);
        t_data res;
        if (v > SUM_MAX) begin
            res = t_data'(SUM_MAX);
        end else if (v < SUM_MIN) begin
            res = t_data'(SUM_MIN);
        end else begin
            res = t_data'(v);
        end
        return res;
    endfunction

    // Hold this cell's coefficient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_re <= '0;
            r_coef_im <= '0;
        end else if (i_wr) begin
            r_coef_re <= i_wr_re;
            r_coef_im <= i_wr_im;
        end
    end

    // Form the four partial products of y * x
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_link.valid;
            if (i_link.valid) begin
                r_p_rr <= t_prod'(i_link.y_re) * t_prod'(i_link.x_re);
                r_p_ii <= t_prod'(i_link.y_im) * t_prod'(i_link.x_im);
                r_p_ri <= t_prod'(i_link.y_re) * t_prod'(i_link.x_im);
                r_p_ir <= t_prod'(i_link.y_im) * t_prod'(i_link.x_re);
                r_x_re <= i_link.x_re;
                r_x_im <= i_link.x_im;
                r_ovf1 <= i_link.ovf;
            end
        end
    end

    // Scale products, add the coefficient, saturate
    always_comb begin
        w_sum_re = t_sum'(r_p_rr >>> FRAC_BITS) - t_sum'(r_p_ii >>> FRAC_BITS)
                 + t_sum'(r_coef_re);
        w_sum_im = t_sum'(r_p_ri >>> FRAC_BITS) + t_sum'(r_p_ir >>> FRAC_BITS)
                 + t_sum'(r_coef_im);
        w_ovf_re = (w_sum_re > SUM_MAX) || (w_sum_re < SUM_MIN);
        w_ovf_im = (w_sum_im > SUM_MAX) || (w_sum_im < SUM_MIN);
        w_sat_re = sat(w_sum_re);
        w_sat_im = sat(w_sum_im);
    end

    // Pass the new partial value to the lower neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else if (i_en) begin
            r_link.valid <= r_v1;
            if (r_v1) begin
                r_link.y_re <= w_sat_re;
                r_link.y_im <= w_sat_im;
                r_link.x_re <= r_x_re;
                r_link.x_im <= r_x_im;
                r_link.ovf  <= r_ovf1 | w_ovf_re | w_ovf_im;
            end
        end
    end

    assign o_link    = r_link;
    assign o_coef_re = r_coef_re;
    assign o_coef_im = r_coef_im;

endmodule

@@ src/complex_horner_poly_eval_core.sv @@
// Channel   Dir  Words                                   Handshake
// i_in      in   func, coef_index, coef_re/im, x_re/im   valid/ready
// o_out     out  y_re, y_im, overflow                    valid/ready
// i_cfg     in   poly_order (i_cfg_wdata)                i_cfg_we, no wait
//
// A load word writes the coefficient register of one cell.
// An evaluate word of order n >= 1 walks down cells n-1..0; each cell registers
// the multiply, then the scale/add/saturate; cell 0 feeds the output register.
// Reset clears all coefficients; order zero takes the bypass register to the output.
// One evaluate word is in flight at a time; i_in.ready is low while it is.
// A full, stalled output register freezes the cell row while a finished word waits.
module complex_horner_poly_eval_core import chpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    chpe_in_if.sink           i_in,
    chpe_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [ORD_W-1:0]  i_cfg_wdata
);

    logic [ORD_W-1:0]  r_order;
    logic              r_busy;
    t_link             r_byp;
    logic              r_out_valid;
    t_data             r_y_re;
    t_data             r_y_im;
    logic              r_ovf;

    logic [CELL_W-1:0] w_n;
    logic [CELL_W-1:0] w_n_m1;
    logic              w_in_acc;
    logic              w_load;
    logic              w_eval;
    logic              w_en;
    logic              w_out_load;
    t_link             w_inject;
    t_link             w_end;
    t_data             w_top_re;
    t_data             w_top_im;

    t_link             w_in_link  [NUM_CELLS];
    t_link             w_chain    [NUM_CELLS];
    t_link             w_out_link [NUM_CELLS];
    t_data             w_coef_re  [NUM_CELLS];
    t_data             w_coef_im  [NUM_CELLS];
    logic              w_wr       [NUM_CELLS];
    logic [NUM_CELLS:0] w_vld;

    // Clamp the order to the table size
    assign w_n    = (int'(r_order) > MAX_ORDER) ? CELL_W'(MAX_ORDER) : CELL_W'(r_order);
    assign w_n_m1 = w_n - CELL_W'(1);

    assign i_in.ready = !r_busy;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_load     = w_in_acc && (i_in.func == FUNC_LOAD);
    assign w_eval     = w_in_acc && (i_in.func == FUNC_EVAL);

    // Start value is the top coefficient
    assign w_top_re = w_coef_re[w_n];
    assign w_top_im = w_coef_im[w_n];

    always_comb begin
        w_inject.valid = w_eval && (w_n != '0);
        w_inject.y_re  = w_top_re;
        w_inject.y_im  = w_top_im;
        w_inject.x_re  = i_in.x_re;
        w_inject.x_im  = i_in.x_im;
        w_inject.ovf   = 1'b0;
    end

    // Row of Horner cells, one per power
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k < MAX_ORDER) begin : g_mid
            assign w_chain[k] = w_out_link[k+1];
        end else begin : g_top
            assign w_chain[k] = '0;
        end

        assign w_in_link[k] = (w_inject.valid && (w_n_m1 == CELL_W'(k))) ?
                              w_inject : w_chain[k];
        assign w_wr[k]      = w_load && (int'(i_in.coef_index) == k);
        assign w_vld[k]     = w_out_link[k].valid;

        chpe_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_link    (w_in_link[k]),
            .i_wr      (w_wr[k]),
            .i_wr_re   (i_in.coef_re),
            .i_wr_im   (i_in.coef_im),
            .o_link    (w_out_link[k]),
            .o_coef_re (w_coef_re[k]),
            .o_coef_im (w_coef_im[k])
        );
    end
    assign w_vld[NUM_CELLS] = r_byp.valid;

    // Finished word comes from cell 0 or from the order-zero bypass
    assign w_end      = r_byp.valid ? r_byp : w_out_link[0];
    assign w_en       = !(w_end.valid && r_out_valid && !o_out.ready);
    assign w_out_load = w_end.valid && w_en;

    // Hold the order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // Track the word in flight and the order-zero bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_byp.valid <= 1'b0;
        end else begin
            if (w_eval) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end

            if (w_eval && (w_n == '0)) begin
                r_byp.valid <= 1'b1;
                r_byp.y_re  <= w_top_re;
                r_byp.y_im  <= w_top_im;
                r_byp.x_re  <= i_in.x_re;
                r_byp.x_im  <= i_in.x_im;
                r_byp.ovf   <= 1'b0;
            end else if (w_out_load) begin
                r_byp.valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
            r_y_re      <= w_end.y_re;
            r_y_im      <= w_end.y_im;
            r_ovf       <= w_end.ovf;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.y_re     = r_y_re;
    assign o_out.y_im     = r_y_im;
    assign o_out.overflow = r_ovf;

    // At most one word moves through the row
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one word in the cell row");

    // A finished word belongs to an accepted evaluate word
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.valid |-> r_busy)
        else $error("result without a word in flight");

    // New words enter only into an empty row
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (w_vld == '0))
        else $error("word accepted while the row is busy");

    // Delivering the result frees the block
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (!r_busy && r_out_valid))
        else $error("block not released after result load");

endmodule

@@ verif/horner_result_checker.sv @@
module horner_result_checker import chpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    chpe_in_if                i_word,
    chpe_out_if               i_result,
    input  logic              i_cfg_we,
    input  logic [ORD_W-1:0]  i_cfg_wdata,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct {
        t_data y_re;
        t_data y_im;
        logic  ovf;
    } t_poly_value;

    // Shadow copy of the coefficient table and the order register
    t_data            coef_re_tbl [NUM_CELLS];
    t_data            coef_im_tbl [NUM_CELLS];
    logic [ORD_W-1:0] order_q;

    // Polynomial values still owed by the block, oldest first
    t_poly_value      owed_values [$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    // Clamp an exact sum to the data width and flag it when clamped
    function automatic t_data clamp_sum(input longint sum, inout logic ovf);
        if (sum > SAT_HI) begin
            ovf = 1'b1;
            return t_data'(SAT_HI);
        end
        if (sum < SAT_LO) begin
            ovf = 1'b1;
            return t_data'(SAT_LO);
        end
        return t_data'(sum);
    endfunction

    // Horner walk over the shadow table at point x
    function automatic t_poly_value horner_eval(input t_data x_re, input t_data x_im);
        t_poly_value acc;
        longint      sum_re;
        longint      sum_im;
        logic        ovf;
        int          top;
        top    = (order_q > MAX_ORDER) ? MAX_ORDER : int'(order_q);
        acc.y_re = coef_re_tbl[top];
        acc.y_im = coef_im_tbl[top];
        ovf    = 1'b0;
        for (int m = top - 1; m >= 0; m--) begin
            sum_re = ((longint'(acc.y_re) * longint'(x_re)) >>> FRAC_BITS)
                   - ((longint'(acc.y_im) * longint'(x_im)) >>> FRAC_BITS)
                   + longint'(coef_re_tbl[m]);
            sum_im = ((longint'(acc.y_re) * longint'(x_im)) >>> FRAC_BITS)
                   + ((longint'(acc.y_im) * longint'(x_re)) >>> FRAC_BITS)
                   + longint'(coef_im_tbl[m]);
            acc.y_re = clamp_sum(sum_re, ovf);
            acc.y_im = clamp_sum(sum_im, ovf);
        end
        acc.ovf = ovf;
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_poly_value want;
        if (!i_rst_n) begin
            // Clear the shadow state as the block does
            for (int k = 0; k < NUM_CELLS; k++) begin
                coef_re_tbl[k] = '0;
                coef_im_tbl[k] = '0;
            end
            order_q = '0;
            owed_values.delete();
            o_pending <= 0;
        end else begin
            // Track order writes
            if (i_cfg_we) begin
                order_q = i_cfg_wdata;
            end

            // Store loads, predict evaluations
            if (i_word.valid && i_word.ready) begin
                if (i_word.func == FUNC_LOAD) begin
                    if (i_word.coef_index <= MAX_ORDER) begin
                        coef_re_tbl[i_word.coef_index] = i_word.coef_re;
                        coef_im_tbl[i_word.coef_index] = i_word.coef_im;
                    end
                end else begin
                    owed_values.push_back(horner_eval(i_word.x_re, i_word.x_im));
                end
            end

            // Compare each result word against the oldest prediction
            if (i_result.valid && i_result.ready) begin
                if (owed_values.size() == 0) begin
                    report_mismatch($sformatf("result word y=(%h,%h) with none owed",
                                              i_result.y_re, i_result.y_im));
                end else begin
                    want = owed_values.pop_front();
                    if (i_result.y_re !== want.y_re)
                        report_mismatch($sformatf("y_re got %h want %h",
                                                  i_result.y_re, want.y_re));
                    if (i_result.y_im !== want.y_im)
                        report_mismatch($sformatf("y_im got %h want %h",
                                                  i_result.y_im, want.y_im));
                    if (i_result.overflow !== want.ovf)
                        report_mismatch($sformatf("overflow got %b want %b",
                                                  i_result.overflow, want.ovf));
                end
            end
            o_pending <= owed_values.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
module testbench import chpe_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    SETTLE_CYCLES   = 2 * MAX_ORDER + 10;
    localparam int    NUM_PHASES      = 10;
    localparam int    ITEMS_PER_PHASE = 110;
    localparam t_data Q_MAX           = 32'sh7FFF_FFFF;
    localparam t_data Q_MIN           = 32'sh8000_0000;
    localparam t_data Q_ONE           = 32'sh0001_0000;
    localparam t_data Q_NEG_ONE       = 32'shFFFF_0000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [ORD_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    bit               in_burst  = 1'b0;
    bit               out_burst = 1'b0;

    chpe_in_if  in_ch ();
    chpe_out_if out_ch ();

    complex_horner_poly_eval_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    horner_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (in_ch),
        .i_result     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_data pick_extreme();
        case ($urandom_range(0, 6))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            4:       return t_data'(1);
            5:       return Q_ONE;
            default: return Q_NEG_ONE;
        endcase
    endfunction

    // Mostly small coefficients so that long walks stay in range
    function automatic t_data rand_coef();
        case ($urandom_range(0, 9))
            0, 1:    return t_data'($urandom);
            2:       return pick_extreme();
            default: return t_data'($urandom_range(0, 32'h3FFFF)) - t_data'(32'h20000);
        endcase
    endfunction

    // Mostly points within unit magnitude per part
    function automatic t_data rand_point();
        case ($urandom_range(0, 9))
            0, 1:    return t_data'($urandom);
            2:       return pick_extreme();
            default: return t_data'($urandom_range(0, 32'h1FFFF)) - Q_ONE;
        endcase
    endfunction

    // Present one word after a random gap and hold it until taken
    task automatic send_word(input t_func func, input logic [IDX_W-1:0] idx,
                             input t_data c_re, input t_data c_im,
                             input t_data p_re, input t_data p_im);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.func       <= func;
        in_ch.coef_index <= idx;
        in_ch.coef_re    <= c_re;
        in_ch.coef_im    <= c_im;
        in_ch.x_re       <= p_re;
        in_ch.x_im       <= p_im;
        in_ch.valid      <= 1'b1;
        @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge i_clk);
    endtask

    task automatic load_coef(input logic [IDX_W-1:0] idx, input t_data c_re, input t_data c_im);
        send_word(FUNC_LOAD, idx, c_re, c_im, t_data'($urandom), t_data'($urandom));
    endtask

    task automatic eval_at(input t_data p_re, input t_data p_im);
        send_word(FUNC_EVAL, IDX_W'($urandom), t_data'($urandom), t_data'($urandom),
                  p_re, p_im);
    endtask

    // Drop valid, then wait out every owed result and the pipeline depth
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [ORD_W-1:0] order);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= order;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall before each word, sometimes none at all
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [ORD_W-1:0] order;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_LOAD;
        in_ch.coef_index <= '0;
        in_ch.coef_re    <= '0;
        in_ch.coef_im    <= '0;
        in_ch.x_re       <= '0;
        in_ch.x_im       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Order zero: cleared table, then a loaded constant term
        eval_at('0, '0);
        load_coef('0, Q_MAX, Q_MIN);
        eval_at(Q_MIN, Q_MAX);

        // Full order with extreme coefficients and points
        write_order(ORD_W'(MAX_ORDER));
        load_coef(IDX_W'(MAX_ORDER), Q_MAX, Q_MAX);
        eval_at(Q_MAX, Q_MAX);
        eval_at('0, '0);
        eval_at(Q_ONE, '0);
        eval_at(Q_MIN, Q_MIN);
        eval_at(Q_NEG_ONE, '0);
        load_coef(IDX_W'(MAX_ORDER), Q_ONE, '0);
        load_coef('0, '0, Q_NEG_ONE);
        load_coef(4'hA, Q_MIN, Q_ONE);
        load_coef(4'h5, Q_NEG_ONE, Q_MAX);
        eval_at('0, Q_ONE);
        eval_at(Q_MAX, Q_MIN);
        eval_at('1, '1);

        // Single step, with and without saturation
        write_order(ORD_W'(1));
        load_coef(IDX_W'(1), Q_ONE, Q_ONE);
        eval_at(Q_MAX, Q_MAX);
        eval_at(Q_NEG_ONE, Q_ONE);
        eval_at(Q_MIN, t_data'(1));

        // Random phases, each at its own order and idling mix
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       order = ORD_W'(MAX_ORDER);
                1:       order = '0;
                2:       order = ORD_W'(1);
                3:       order = ORD_W'(2);
                4:       order = ORD_W'(MAX_ORDER);
                default: order = ORD_W'($urandom);
            endcase
            write_order(order);
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 3) == 0)
                    load_coef(IDX_W'($urandom), rand_coef(), rand_coef());
                else
                    eval_at(rand_point(), rand_point());
            end
        end

        drain();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
